@@ hdl/mtf_pkg.sv @@
// ----------------------------------------------------------------------------
// mtf_pkg
// Shared types, constants and control program for the telemetry framer.
// ----------------------------------------------------------------------------
package mtf_pkg;

  localparam int FRAME_BYTES = 41;
  localparam int STEP_W      = $clog2(FRAME_BYTES);
  localparam int VEC_BYTES   = 32;
  localparam int SEL_W       = $clog2(VEC_BYTES);

  localparam logic [7:0] SYNC_HI     = 8'h5A;
  localparam logic [7:0] SYNC_LO     = 8'hE1;
  localparam logic [7:0] FMT_VERSION = 8'h01;
  localparam logic [7:0] PAYLOAD_LEN = 8'd28;
  localparam logic [7:0] CRC_POLY    = 8'h07;
  localparam logic [7:0] FLAGS_BASE  = 8'h05;

  // byte-vector layout: flags, MAC msb first, then little-endian data fields
  localparam int VEC_FLAGS = 0;
  localparam int VEC_MAC   = 1;
  localparam int VEC_DATA  = 7;

  typedef struct packed {
    logic        relay_closed;
    logic        relay_command;
    logic [15:0] voltage_decivolts;
    logic [23:0] current_milliamps;
    logic [20:0] power_watts;
    logic [15:0] power_factor_milli;
    logic [15:0] frequency_decihertz;
    logic [30:0] energy_centi_kwh;
    logic [31:0] uptime_seconds;
  } in_t;

  typedef struct packed {
    logic [7:0] frame_byte;
    logic       last_byte;
  } out_t;

  typedef enum logic [1:0] {
    SRC_LIT,
    SRC_VEC,
    SRC_CRC
  } src_t;

  // one control word per program step
  typedef struct packed {
    logic             wait_in;  // hold here until a snapshot arrives; load it
    src_t             src;
    logic [SEL_W-1:0] sel;
    logic [7:0]       lit;
    logic             last;     // final byte, jump back to step 0
  } ucode_t;

  // datapath control for the current step
  typedef struct packed {
    logic             go;
    logic             load;
    src_t             src;
    logic [SEL_W-1:0] sel;
    logic [7:0]       lit;
    logic             last;
  } ctrl_t;

  function automatic ucode_t ucode(input logic [STEP_W-1:0] step);
    ucode_t w;
    w.wait_in = 1'b0;
    w.src     = SRC_LIT;
    w.sel     = '0;
    w.lit     = 8'h00;
    w.last    = 1'b0;
    case (step) inside
      STEP_W'(0): begin
        w.wait_in = 1'b1;
        w.lit     = SYNC_HI;
      end
      STEP_W'(1): w.lit = SYNC_LO;
      STEP_W'(2): w.lit = FMT_VERSION;
      STEP_W'(3): begin
        w.src = SRC_VEC;
        w.sel = SEL_W'(VEC_FLAGS);
      end
      STEP_W'(4): w.lit = 8'h00;
      [STEP_W'(5):STEP_W'(10)]: begin
        w.src = SRC_VEC;
        w.sel = SEL_W'(step - STEP_W'(5 - VEC_MAC));
      end
      STEP_W'(11): w.lit = PAYLOAD_LEN;
      STEP_W'(12): w.lit = 8'h00;
      [STEP_W'(13):STEP_W'(36)]: begin
        w.src = SRC_VEC;
        w.sel = SEL_W'(step - STEP_W'(13 - VEC_DATA));
      end
      STEP_W'(FRAME_BYTES - 1): begin
        w.src  = SRC_CRC;
        w.last = 1'b1;
      end
      default: w.lit = 8'h00;  // reserved bytes
    endcase
    return w;
  endfunction

  // CRC-8, msb first, no reflection
  function automatic logic [7:0] crc8_byte(input logic [7:0] crc, input logic [7:0] b);
    logic [7:0] c;
    c = crc ^ b;
    for (int k = 0; k < 8; k++) begin
      c = c[7] ? ({c[6:0], 1'b0} ^ CRC_POLY) : {c[6:0], 1'b0};
    end
    return c;
  endfunction

endpackage

@@ hdl/mtf_sequencer.sv @@
// ----------------------------------------------------------------------------
// mtf_sequencer
// Step counter over the framer's control program; one step per output word.
// ----------------------------------------------------------------------------
module mtf_sequencer (
  input  logic           clk,
  input  logic           rst,
  input  logic           in_valid,
  output logic           in_ready,
  input  logic           slot_free,
  output mtf_pkg::ctrl_t ctrl
);

  logic [mtf_pkg::STEP_W-1:0] step;
  logic [mtf_pkg::STEP_W-1:0] step_next;
  mtf_pkg::ucode_t            cw;
  logic                       go;

  assign cw       = mtf_pkg::ucode(step);
  assign in_ready = cw.wait_in & slot_free;
  assign go       = slot_free & (~cw.wait_in | in_valid);

  assign step_next = cw.last ? '0 : step + 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      step <= '0;
    end else if (go) begin
      step <= step_next;
    end
  end

  assign ctrl.go   = go;
  assign ctrl.load = cw.wait_in;
  assign ctrl.src  = cw.src;
  assign ctrl.sel  = cw.sel;
  assign ctrl.lit  = cw.lit;
  assign ctrl.last = cw.last;

endmodule

@@ hdl/mtf_datapath.sv @@
// ----------------------------------------------------------------------------
// mtf_datapath
// Snapshot registers, byte select, running CRC and output register.
// ----------------------------------------------------------------------------
module mtf_datapath (
  input  logic           clk,
  input  logic           rst,
  input  mtf_pkg::in_t   snap_in,
  input  logic           mac_we,
  input  logic [47:0]    mac_wdata,
  input  mtf_pkg::ctrl_t ctrl,
  output logic           slot_free,
  output logic           out_valid,
  input  logic           out_ready,
  output mtf_pkg::out_t  out_data
);

  logic [47:0]  mac;
  logic [7:0]   flags;
  logic [191:0] data_le;
  logic [7:0]   crc;
  logic [7:0]   byte_sel;
  logic [7:0]   vec [mtf_pkg::VEC_BYTES];
  logic [23:0]  power_x10;
  logic [40:0]  energy_x1000;

  // power * 10 keeps the low 24 bits
  assign power_x10 = 24'({snap_in.power_watts, 3'b000}) + 24'({snap_in.power_watts, 1'b0});
  // energy * 1000 = x*1024 - x*16 - x*8
  assign energy_x1000 = (41'(snap_in.energy_centi_kwh) << 10)
                      - (41'(snap_in.energy_centi_kwh) << 4)
                      - (41'(snap_in.energy_centi_kwh) << 3);

  always_ff @(posedge clk) begin
    if (rst) begin
      mac <= '0;
    end else if (mac_we) begin
      mac <= mac_wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (ctrl.go && ctrl.load) begin
      flags   <= mtf_pkg::FLAGS_BASE | {4'b0000, snap_in.relay_command, 1'b0,
                                        snap_in.relay_closed, 1'b0};
      data_le <= {snap_in.uptime_seconds, 23'd0, energy_x1000,
                  snap_in.frequency_decihertz, snap_in.power_factor_milli,
                  power_x10, snap_in.current_milliamps, snap_in.voltage_decivolts};
    end
  end

  always_comb begin
    for (int i = 0; i < mtf_pkg::VEC_BYTES; i++) begin
      vec[i] = 8'h00;
    end
    vec[mtf_pkg::VEC_FLAGS] = flags;
    for (int i = 0; i < 6; i++) begin
      vec[mtf_pkg::VEC_MAC + i] = mac[8*(5-i) +: 8];
    end
    for (int i = 0; i < 24; i++) begin
      vec[mtf_pkg::VEC_DATA + i] = data_le[8*i +: 8];
    end
  end

  always_comb begin
    case (ctrl.src)
      mtf_pkg::SRC_LIT: byte_sel = ctrl.lit;
      mtf_pkg::SRC_VEC: byte_sel = vec[ctrl.sel];
      mtf_pkg::SRC_CRC: byte_sel = crc;
      default:          byte_sel = 8'h00;
    endcase
  end

  // first word of a frame restarts the CRC from zero
  always_ff @(posedge clk) begin
    if (rst) begin
      crc <= '0;
    end else if (ctrl.go) begin
      crc <= mtf_pkg::crc8_byte(ctrl.load ? 8'h00 : crc, byte_sel);
    end
  end

  assign slot_free = ~out_valid | out_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (ctrl.go) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (ctrl.go) begin
      out_data.frame_byte <= byte_sel;
      out_data.last_byte  <= ctrl.last;
    end
  end

endmodule

@@ hdl/meter_telemetry_framer_crc8.sv @@
// ----------------------------------------------------------------------------
// meter_telemetry_framer_crc8
// Turns one energy-meter snapshot into a 41-byte telemetry frame with CRC-8.
// ----------------------------------------------------------------------------
// Input channel (in_valid/in_ready/in_data) takes one snapshot word; the
// output channel (out_valid/out_ready/out_data) sends the frame one byte per
// word, last_byte marking the trailing CRC byte. mac_we/mac_wdata set the
// station MAC; the user must write it only while no frame is in flight;
// the block does not enforce this. A short control program steps through the
// frame, one step per byte. The snapshot is taken in step 0, which also
// issues the first byte, so the first byte appears in the cycle after
// acceptance. The next snapshot can be accepted only once the step counter
// returns to step 0 after the CRC byte and the output slot is free.
// The output register is the only buffer: a stall on out_ready freezes the
// step counter and the CRC until the waiting byte is taken. in_ready is high
// only at step 0 while the output slot is free.
// Reset clears the step counter, CRC, output valid and the MAC (to zero).
// ----------------------------------------------------------------------------
module meter_telemetry_framer_crc8 (
  input  logic          clk,
  input  logic          rst,
  input  logic          in_valid,
  output logic          in_ready,
  input  mtf_pkg::in_t  in_data,
  output logic          out_valid,
  input  logic          out_ready,
  output mtf_pkg::out_t out_data,
  input  logic          mac_we,
  input  logic [47:0]   mac_wdata
);

  mtf_pkg::ctrl_t ctrl;
  logic           slot_free;

  mtf_sequencer u_seq (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .slot_free (slot_free),
    .ctrl      (ctrl)
  );

  mtf_datapath u_dp (
    .clk       (clk),
    .rst       (rst),
    .snap_in   (in_data),
    .mac_we    (mac_we),
    .mac_wdata (mac_wdata),
    .ctrl      (ctrl),
    .slot_free (slot_free),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data)
  );

endmodule
